// ===== design/sfr_pkg.sv =====
package sfr_pkg;

    localparam int unsigned FRAME_BUFFER_BYTES = 256;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_FRAMING_MODE = 1'b0;

    localparam logic [7:0] BYTE_SLIP_END     = 8'hC0;
    localparam logic [7:0] BYTE_SLIP_ESC     = 8'hDB;
    localparam logic [7:0] BYTE_SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] BYTE_SLIP_ESC_ESC = 8'hDD;
    localparam logic [7:0] BYTE_DOLLAR       = 8'h24;
    localparam logic [7:0] BYTE_LINE_FEED    = 8'h0A;
    localparam logic [7:0] BYTE_SYNC1        = 8'hB5;
    localparam logic [7:0] BYTE_SYNC2        = 8'h62;

    localparam logic MODE_SLIP = 1'b0;
    localparam logic MODE_GNSS = 1'b1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_COMMIT = 2'd1;
    localparam logic [1:0] EV_DROP   = 2'd2;

    localparam logic [1:0] KIND_SLIP = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_BIN  = 2'd2;

endpackage

// ===== design/serial_frame_receiver.sv =====
// serial_frame_receiver: byte-at-a-time deframer for a UART receive stream.
// Input channel (s_valid/s_ready, s_rx_byte) takes one received byte per item.
// Result channel (m_valid/m_ready) gives exactly one result item per byte: an
// optional frame buffer write (m_write_enable/addr/data) and an optional frame
// event (commit or drop) with its length and kind.
// framing_mode (APB, address 0): 0 SLIP deframing, 1 GNSS text line/binary
// packet parsing. A write abandons any frame in progress, no event given.
// The result of a byte is registered: it is on the m_ side in the cycle after
// the byte is taken. Throughput: one byte per cycle while the receiver takes
// results; the parser state and the result register update in the same cycle,
// so bytes can follow back to back. When the receiver stalls, the result is
// held and one more byte cannot be taken until it leaves: s_ready is low while
// a result waits and m_ready is low.
// Reset (aresetn low, synchronous): SLIP mode, waiting for the first END,
// counters and checksums cleared, no result pending.
module serial_frame_receiver #(
    parameter int unsigned FRAME_BUFFER_BYTES = sfr_pkg::FRAME_BUFFER_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_write_enable,
    output logic [7:0]                      m_write_addr,
    output logic [7:0]                      m_write_data,
    output logic [1:0]                      m_frame_event,
    output logic [7:0]                      m_frame_length,
    output logic [1:0]                      m_frame_kind,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int unsigned CNT_W = $clog2(FRAME_BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_BUFFER_BYTES - 1);

    typedef enum logic [3:0] {
        PH_RESYNC,
        PH_SLIP,
        PH_HUNT,
        PH_TEXT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    logic              mode_reg;
    phase_t            phase_reg,      phase_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic              esc_reg,        esc_next;
    logic [7:0]        sum_a_reg,      sum_a_next;
    logic [7:0]        sum_b_reg,      sum_b_next;
    logic [15:0]       pay_len_reg,    pay_len_next;
    logic [15:0]       pay_cnt_reg,    pay_cnt_next;

    logic              m_valid_reg;
    logic              we_reg,         we_next;
    logic [7:0]        addr_reg,       addr_next;
    logic [7:0]        data_reg,       data_next;
    logic [1:0]        event_reg,      event_next;
    logic [7:0]        len_reg,        len_next;
    logic [1:0]        kind_reg,       kind_next;

    logic              cfg_write;
    logic              take;
    logic [7:0]        b;
    logic [7:0]        acc_a;
    logic [7:0]        acc_b;
    logic [15:0]       pay_cnt_inc;

    assign pready    = 1'b1;
    assign prdata    = {{(sfr_pkg::APB_DATA_W-1){1'b0}}, mode_reg};
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == sfr_pkg::REG_FRAMING_MODE);

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign b       = s_rx_byte;

    assign acc_a       = sum_a_reg + b;
    assign acc_b       = sum_b_reg + acc_a;
    assign pay_cnt_inc = pay_cnt_reg + 16'd1;

    always_comb begin
        logic             do_store;
        logic             do_finish;
        logic             ok;
        logic [1:0]       kind;
        logic [CNT_W-1:0] cnt;

        do_store  = 1'b0;
        do_finish = 1'b0;
        ok        = 1'b1;
        kind      = sfr_pkg::KIND_SLIP;

        phase_next   = phase_reg;
        esc_next     = esc_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        pay_len_next = pay_len_reg;
        pay_cnt_next = pay_cnt_reg;
        cnt          = count_reg;

        case (phase_reg)
            PH_RESYNC: begin
                if (b == sfr_pkg::BYTE_SLIP_END) begin
                    phase_next = PH_SLIP;
                    cnt        = '0;
                    esc_next   = 1'b0;
                end
            end
            PH_SLIP: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    do_store = (b == sfr_pkg::BYTE_SLIP_ESC_ESC)
                               || (b == sfr_pkg::BYTE_SLIP_ESC_END);
                end else if (b == sfr_pkg::BYTE_SLIP_END) begin
                    do_finish = 1'b1;
                end else if (b == sfr_pkg::BYTE_SLIP_ESC) begin
                    esc_next = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_HUNT: begin
                if (b == sfr_pkg::BYTE_DOLLAR) begin
                    do_store   = 1'b1;
                    phase_next = PH_TEXT;
                end else if (b == sfr_pkg::BYTE_SYNC1) begin
                    do_store   = 1'b1;
                    sum_a_next = '0;
                    sum_b_next = '0;
                    phase_next = PH_SYNC2;
                end
            end
            PH_TEXT: begin
                do_store = 1'b1;
                if (b == sfr_pkg::BYTE_LINE_FEED) begin
                    do_finish  = 1'b1;
                    kind       = sfr_pkg::KIND_TEXT;
                    phase_next = PH_HUNT;
                end
            end
            PH_SYNC2: begin
                do_store = 1'b1;
                if (b == sfr_pkg::BYTE_SYNC2) begin
                    phase_next = PH_CLASS;
                end else begin
                    do_finish  = 1'b1;
                    ok         = 1'b0;
                    kind       = sfr_pkg::KIND_BIN;
                    phase_next = PH_HUNT;
                end
            end
            PH_CLASS, PH_ID: begin
                do_store   = 1'b1;
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                phase_next = (phase_reg == PH_CLASS) ? PH_ID : PH_LEN_LO;
            end
            PH_LEN_LO: begin
                do_store     = 1'b1;
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
                pay_len_next = {8'h00, b};
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                do_store     = 1'b1;
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
                pay_len_next = {b, pay_len_reg[7:0]};
                pay_cnt_next = '0;
                phase_next   = ({b, pay_len_reg[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                do_store     = 1'b1;
                sum_a_next   = acc_a;
                sum_b_next   = acc_b;
                pay_cnt_next = pay_cnt_inc;
                if (pay_cnt_inc == pay_len_reg) begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A: begin
                do_store = 1'b1;
                if (b == sum_a_reg) begin
                    phase_next = PH_CK_B;
                end else begin
                    do_finish  = 1'b1;
                    ok         = 1'b0;
                    kind       = sfr_pkg::KIND_BIN;
                    phase_next = PH_HUNT;
                end
            end
            PH_CK_B: begin
                do_store   = 1'b1;
                do_finish  = 1'b1;
                ok         = (b == sum_b_reg);
                kind       = sfr_pkg::KIND_BIN;
                phase_next = PH_HUNT;
            end
            default: begin
                phase_next   = (mode_reg == sfr_pkg::MODE_GNSS) ? PH_HUNT : PH_RESYNC;
                cnt          = '0;
                esc_next     = 1'b0;
                sum_a_next   = '0;
                sum_b_next   = '0;
                pay_len_next = '0;
                pay_cnt_next = '0;
            end
        endcase

        // store: HUNT restarts the index at zero before writing
        we_next   = do_store;
        addr_next = '0;
        data_next = '0;
        if (do_store) begin
            if (phase_reg == PH_HUNT) begin
                cnt = '0;
            end
            addr_next = 8'(cnt);
            if (phase_reg == PH_SLIP && esc_reg) begin
                data_next = (b == sfr_pkg::BYTE_SLIP_ESC_ESC) ? sfr_pkg::BYTE_SLIP_ESC
                                                              : sfr_pkg::BYTE_SLIP_END;
            end else begin
                data_next = b;
            end
            cnt = (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
        end

        event_next = sfr_pkg::EV_NONE;
        len_next   = '0;
        kind_next  = sfr_pkg::KIND_SLIP;
        if (do_finish) begin
            kind_next = kind;
            if (ok && cnt != '0 && cnt != CNT_MAX) begin
                event_next = sfr_pkg::EV_COMMIT;
                len_next   = 8'(cnt);
            end else begin
                event_next = sfr_pkg::EV_DROP;
            end
            cnt = '0;
        end
        count_next = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= sfr_pkg::MODE_SLIP;
            phase_reg   <= PH_RESYNC;
            count_reg   <= '0;
            esc_reg     <= 1'b0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            pay_len_reg <= '0;
            pay_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                mode_reg    <= pwdata[0];
                phase_reg   <= (pwdata[0] == sfr_pkg::MODE_GNSS) ? PH_HUNT : PH_RESYNC;
                count_reg   <= '0;
                esc_reg     <= 1'b0;
                sum_a_reg   <= '0;
                sum_b_reg   <= '0;
                pay_len_reg <= '0;
                pay_cnt_reg <= '0;
            end else if (take) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                esc_reg     <= esc_next;
                sum_a_reg   <= sum_a_next;
                sum_b_reg   <= sum_b_next;
                pay_len_reg <= pay_len_next;
                pay_cnt_reg <= pay_cnt_next;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (take) begin
            we_reg    <= we_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            event_reg <= event_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = we_reg;
    assign m_write_addr   = addr_reg;
    assign m_write_data   = data_reg;
    assign m_frame_event  = event_reg;
    assign m_frame_length = len_reg;
    assign m_frame_kind   = kind_reg;

`ifndef SYNTH
    // escape state only lives inside a SLIP frame
    a_esc_in_slip: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (phase_reg == PH_SLIP))
        else $error("escape pending outside SLIP frame");

    // index never passes the saturated position
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("byte index beyond buffer");

    // no event means no kind and no length
    a_no_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_event == sfr_pkg::EV_NONE)
        |-> (m_frame_kind == sfr_pkg::KIND_SLIP && m_frame_length == 8'd0))
        else $error("kind or length without event");

    // SLIP mode only ever reports SLIP frames
    a_slip_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && mode_reg == sfr_pkg::MODE_SLIP)
        |=> (m_frame_kind == sfr_pkg::KIND_SLIP))
        else $error("non-SLIP frame kind in SLIP mode");
`endif

endmodule

// ===== test/serial_frame_receiver_tb.sv =====
module serial_frame_receiver_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 1400;
    localparam int QUIET_BYTES  = 250;
    localparam int LONG_HOLD    = 80;
    localparam int SPARE_REG    = 1;
    localparam int ADDR_W       = sfr_pkg::APB_ADDR_W;
    localparam int DATA_W       = sfr_pkg::APB_DATA_W;

    localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'(4 * sfr_pkg::REG_FRAMING_MODE);
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * SPARE_REG);

    typedef enum {PKT_GOOD, PKT_BAD_SYNC, PKT_BAD_CK_A, PKT_BAD_CK_B} pkt_fault_t;

    typedef struct {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
        logic [1:0] ev;
        logic [7:0] len;
        logic [1:0] kind;
    } rx_result_t;

    class frame_scoreboard_t;
        typedef enum bit [3:0] {
            SEEK_END, IN_FRAME, HUNT, TEXT_LINE, SYNC2, MSG_CLASS, MSG_ID,
            LEN_LO, LEN_HI, PAYLOAD, CK_A, CK_B
        } phase_t;

        bit         mode;
        phase_t     phase;
        int         count;
        bit         esc;
        bit [7:0]   sum_a;
        bit [7:0]   sum_b;
        bit [15:0]  pay_len;
        bit [15:0]  pay_cnt;
        rx_result_t nxt;
        rx_result_t expected_q[$];
        int         fails;
        int         commits;
        int         drops;

        function new();
            fails   = 0;
            commits = 0;
            drops   = 0;
            mode    = sfr_pkg::MODE_SLIP;
            restart();
        endfunction

        function void restart();
            if (mode == sfr_pkg::MODE_GNSS) begin
                phase = HUNT;
            end else begin
                phase = SEEK_END;
            end
            count   = 0;
            esc     = 0;
            sum_a   = 0;
            sum_b   = 0;
            pay_len = 0;
            pay_cnt = 0;
        endfunction

        function void set_mode(bit m);
            mode = m;
            restart();
        endfunction

        function void put_byte(logic [7:0] b);
            nxt.we   = 1'b1;
            nxt.addr = count[7:0];
            nxt.data = b;
            count++;
            if (count >= sfr_pkg::FRAME_BUFFER_BYTES) begin
                count = sfr_pkg::FRAME_BUFFER_BYTES - 1;
            end
        endfunction

        function void close_frame(logic [1:0] kind, bit ok);
            if (ok && count != 0 && count != sfr_pkg::FRAME_BUFFER_BYTES - 1) begin
                nxt.ev  = sfr_pkg::EV_COMMIT;
                nxt.len = count[7:0];
            end else begin
                nxt.ev  = sfr_pkg::EV_DROP;
                nxt.len = '0;
            end
            nxt.kind = kind;
            count    = 0;
        endfunction

        function void add_sum(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void note_byte(logic [7:0] b);
            nxt = '{default: 0};
            case (phase)
                SEEK_END: begin
                    if (b == sfr_pkg::BYTE_SLIP_END) begin
                        phase = IN_FRAME;
                        count = 0;
                        esc   = 0;
                    end
                end
                IN_FRAME: begin
                    if (esc) begin
                        esc = 0;
                        if (b == sfr_pkg::BYTE_SLIP_ESC_ESC) begin
                            put_byte(sfr_pkg::BYTE_SLIP_ESC);
                        end else if (b == sfr_pkg::BYTE_SLIP_ESC_END) begin
                            put_byte(sfr_pkg::BYTE_SLIP_END);
                        end
                    end else if (b == sfr_pkg::BYTE_SLIP_END) begin
                        close_frame(sfr_pkg::KIND_SLIP, 1'b1);
                    end else if (b == sfr_pkg::BYTE_SLIP_ESC) begin
                        esc = 1;
                    end else begin
                        put_byte(b);
                    end
                end
                HUNT: begin
                    if (b == sfr_pkg::BYTE_DOLLAR) begin
                        count = 0;
                        put_byte(b);
                        phase = TEXT_LINE;
                    end else if (b == sfr_pkg::BYTE_SYNC1) begin
                        count = 0;
                        sum_a = 0;
                        sum_b = 0;
                        put_byte(b);
                        phase = SYNC2;
                    end
                end
                TEXT_LINE: begin
                    put_byte(b);
                    if (b == sfr_pkg::BYTE_LINE_FEED) begin
                        close_frame(sfr_pkg::KIND_TEXT, 1'b1);
                        phase = HUNT;
                    end
                end
                SYNC2: begin
                    put_byte(b);
                    if (b == sfr_pkg::BYTE_SYNC2) begin
                        phase = MSG_CLASS;
                    end else begin
                        close_frame(sfr_pkg::KIND_BIN, 1'b0);
                        phase = HUNT;
                    end
                end
                MSG_CLASS: begin
                    put_byte(b);
                    add_sum(b);
                    phase = MSG_ID;
                end
                MSG_ID: begin
                    put_byte(b);
                    add_sum(b);
                    phase = LEN_LO;
                end
                LEN_LO: begin
                    put_byte(b);
                    add_sum(b);
                    pay_len = {8'h00, b};
                    phase = LEN_HI;
                end
                LEN_HI: begin
                    put_byte(b);
                    add_sum(b);
                    pay_len[15:8] = b;
                    pay_cnt = 0;
                    if (pay_len == 0) begin
                        phase = CK_A;
                    end else begin
                        phase = PAYLOAD;
                    end
                end
                PAYLOAD: begin
                    put_byte(b);
                    add_sum(b);
                    pay_cnt++;
                    if (pay_cnt == pay_len) begin
                        phase = CK_A;
                    end
                end
                CK_A: begin
                    put_byte(b);
                    if (b == sum_a) begin
                        phase = CK_B;
                    end else begin
                        close_frame(sfr_pkg::KIND_BIN, 1'b0);
                        phase = HUNT;
                    end
                end
                CK_B: begin
                    put_byte(b);
                    close_frame(sfr_pkg::KIND_BIN, b == sum_b);
                    phase = HUNT;
                end
                default: begin
                    restart();
                end
            endcase
            expected_q.push_back(nxt);
        endfunction

        function void same(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                fails++;
            end
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no received byte waiting for it");
                fails++;
                return;
            end
            want = expected_q.pop_front();
            same("write_enable", 8'(want.we), 8'(got.we));
            same("write_addr", want.addr, got.addr);
            same("write_data", want.data, got.data);
            same("frame_event", 8'(want.ev), 8'(got.ev));
            same("frame_length", want.len, got.len);
            same("frame_kind", 8'(want.kind), 8'(got.kind));
            if (want.ev == sfr_pkg::EV_COMMIT) begin
                commits++;
            end else if (want.ev == sfr_pkg::EV_DROP) begin
                drops++;
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic [7:0]        s_rx_byte = 8'h00;
    logic              m_ready   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;

    logic              s_ready;
    logic              m_valid;
    logic              m_write_enable;
    logic [7:0]        m_write_addr;
    logic [7:0]        m_write_data;
    logic [1:0]        m_frame_event;
    logic [7:0]        m_frame_length;
    logic [1:0]        m_frame_kind;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    frame_scoreboard_t board;
    logic [7:0]        stream_q[$];
    int                sent_bytes  = 0;
    int                noise_bytes = 0;
    int                mode_writes = 0;
    bit                tx_idle_on  = 1'b1;
    bit                rx_idle_on  = 1'b1;
    bit                hold_long   = 1'b0;

    serial_frame_receiver u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_write_addr   (m_write_addr),
        .m_write_data   (m_write_data),
        .m_frame_event  (m_frame_event),
        .m_frame_length (m_frame_length),
        .m_frame_kind   (m_frame_kind),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        rx_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.we   = m_write_enable;
            seen.addr = m_write_addr;
            seen.data = m_write_data;
            seen.ev   = m_frame_event;
            seen.len  = m_frame_length;
            seen.kind = m_frame_kind;
            board.check_result(seen);
        end
        if (aresetn && s_valid && s_ready) begin
            board.note_byte(s_rx_byte);
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left == 0) begin
                if (hold_long) begin
                    stall_left = LONG_HOLD;
                    hold_long  = 1'b0;
                end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 11);
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", board.expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_all();
        while (stream_q.size() > 0) begin
            send_byte(stream_q.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_mode_reg();
        logic [DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        if (rd !== {{(DATA_W - 1){1'b0}}, board.mode}) begin
            $error("framing_mode mismatch: expected 0x%0h, got 0x%0h", board.mode, rd);
            board.fails++;
        end
    endtask

    task automatic write_mode(input bit m);
        apb_write(MODE_ADDR, {{(DATA_W - 1){1'b0}}, m});
        board.set_mode(m);
        mode_writes++;
        check_mode_reg();
    endtask

    task automatic gen_slip_frame(input int n);
        logic [7:0] b;
        logic [7:0] code;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                // escape with an unusual code, END included
                code = ($urandom_range(0, 2) == 0) ? sfr_pkg::BYTE_SLIP_END
                                                   : 8'($urandom_range(0, 255));
                stream_q.push_back(sfr_pkg::BYTE_SLIP_ESC);
                stream_q.push_back(code);
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    b = $urandom_range(0, 1) ? sfr_pkg::BYTE_SLIP_END : sfr_pkg::BYTE_SLIP_ESC;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                if (b == sfr_pkg::BYTE_SLIP_END) begin
                    stream_q.push_back(sfr_pkg::BYTE_SLIP_ESC);
                    stream_q.push_back(sfr_pkg::BYTE_SLIP_ESC_END);
                end else if (b == sfr_pkg::BYTE_SLIP_ESC) begin
                    stream_q.push_back(sfr_pkg::BYTE_SLIP_ESC);
                    stream_q.push_back(sfr_pkg::BYTE_SLIP_ESC_ESC);
                end else begin
                    stream_q.push_back(b);
                end
            end
        end
        stream_q.push_back(sfr_pkg::BYTE_SLIP_END);
    endtask

    task automatic gen_text_line(input int n);
        logic [7:0] b;
        stream_q.push_back(sfr_pkg::BYTE_DOLLAR);
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == sfr_pkg::BYTE_LINE_FEED);
            stream_q.push_back(b);
        end
        stream_q.push_back(sfr_pkg::BYTE_LINE_FEED);
    endtask

    task automatic gen_packet(input logic [15:0] plen, input pkt_fault_t fault);
        logic [7:0] body[$];
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] b;
        sa = 0;
        sb = 0;
        stream_q.push_back(sfr_pkg::BYTE_SYNC1);
        if (fault == PKT_BAD_SYNC) begin
            do b = 8'($urandom_range(0, 255)); while (b == sfr_pkg::BYTE_SYNC2);
            stream_q.push_back(b);
            return;
        end
        stream_q.push_back(sfr_pkg::BYTE_SYNC2);
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(plen[7:0]);
        body.push_back(plen[15:8]);
        for (int i = 0; i < plen; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        foreach (body[i]) begin
            sa = sa + body[i];
            sb = sb + sa;
            stream_q.push_back(body[i]);
        end
        if (fault == PKT_BAD_CK_A) begin
            sa = sa ^ 8'($urandom_range(1, 255));
        end
        if (fault == PKT_BAD_CK_B) begin
            sb = sb ^ 8'($urandom_range(1, 255));
        end
        stream_q.push_back(sa);
        stream_q.push_back(sb);
    endtask

    task automatic gen_noise(input int n, input bit gnss);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (gnss && (b == sfr_pkg::BYTE_DOLLAR || b == sfr_pkg::BYTE_SYNC1)) begin
                b = 8'h00;
            end
            stream_q.push_back(b);
        end
        noise_bytes += n;
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 29) == 0) begin
            return $urandom_range(250, 258);
        end
        return $urandom_range(0, 20);
    endfunction

    function automatic int pick_payload();
        int r;
        r = $urandom_range(0, 59);
        if (r == 0) begin
            return $urandom_range(256, 300);
        end else if (r < 3) begin
            return $urandom_range(244, 250);
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic gen_batch(input bit gnss, input int target);
        int start;
        pkt_fault_t fault;
        start = stream_q.size();
        if (!gnss) begin
            gen_noise($urandom_range(0, 3), gnss);
            stream_q.push_back(sfr_pkg::BYTE_SLIP_END);
        end
        while (stream_q.size() - start < target) begin
            if ($urandom_range(0, 9) < 8) begin
                if (!gnss) begin
                    gen_slip_frame(pick_len());
                end else if ($urandom_range(0, 1)) begin
                    gen_text_line(pick_len());
                end else begin
                    gen_packet(16'(pick_payload()), PKT_GOOD);
                end
            end else if (gnss && $urandom_range(0, 2) != 0) begin
                fault = pkt_fault_t'($urandom_range(1, 3));
                gen_packet(16'($urandom_range(0, 12)), fault);
            end else begin
                gen_noise($urandom_range(1, 8), gnss);
            end
        end
    endtask

    // left unfinished so that the next mode write cuts it off
    task automatic gen_partial(input bit gnss);
        if (!gnss) begin
            repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 191)));
        end else if ($urandom_range(0, 1)) begin
            stream_q.push_back(sfr_pkg::BYTE_DOLLAR);
            repeat ($urandom_range(0, 6)) stream_q.push_back(8'($urandom_range(32, 126)));
        end else begin
            stream_q.push_back(sfr_pkg::BYTE_SYNC1);
            stream_q.push_back(sfr_pkg::BYTE_SYNC2);
            stream_q.push_back(8'($urandom_range(0, 255)));
            stream_q.push_back(8'($urandom_range(0, 255)));
            stream_q.push_back(8'hFF);
            stream_q.push_back(8'hFF);
            repeat ($urandom_range(0, 5)) stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int  base;
        int  step;
        bit  quiet;
        bit  m;
        board = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_mode_reg();

        // SLIP: junk before sync, empty frame, both escapes, escape eating END, bad code
        stream_q = {8'h00, 8'hFF, sfr_pkg::BYTE_SLIP_END, sfr_pkg::BYTE_SLIP_END,
                    8'h00, 8'hFF,
                    sfr_pkg::BYTE_SLIP_ESC, sfr_pkg::BYTE_SLIP_ESC_END,
                    sfr_pkg::BYTE_SLIP_ESC, sfr_pkg::BYTE_SLIP_ESC_ESC,
                    sfr_pkg::BYTE_SLIP_ESC, sfr_pkg::BYTE_SLIP_END,
                    sfr_pkg::BYTE_SLIP_ESC, 8'h11, sfr_pkg::BYTE_SLIP_END};
        send_all();
        wait_drained();
        write_mode(sfr_pkg::MODE_GNSS);

        // shortest line, bad sync, zero-length payload
        stream_q = {sfr_pkg::BYTE_DOLLAR, sfr_pkg::BYTE_LINE_FEED, sfr_pkg::BYTE_SYNC1, 8'h00};
        gen_packet(16'd0, PKT_GOOD);
        send_all();

        base = sent_bytes - noise_bytes;
        step = 0;
        while (sent_bytes - noise_bytes - base < RANDOM_BYTES) begin
            quiet = (sent_bytes - noise_bytes - base) > RANDOM_BYTES - QUIET_BYTES;
            wait_drained();
            if ($urandom_range(0, 3) == 0) begin
                apb_write(SPARE_ADDR, $urandom_range(0, 1));
                check_mode_reg();
            end
            if (step < 2) begin
                m = step[0];
            end else begin
                m = $urandom_range(0, 1);
            end
            write_mode(m);
            tx_idle_on = !quiet && $urandom_range(0, 3) != 0;
            rx_idle_on = !quiet && $urandom_range(0, 3) != 0;
            if (step == 2) begin
                tx_idle_on = 1'b0;
                hold_long  = 1'b1;
            end
            gen_batch(m, $urandom_range(80, 200));
            send_all();
            if (step == 3) begin
                wait_drained();
                gen_batch(m, $urandom_range(40, 100));
                send_all();
            end
            if ($urandom_range(0, 2) == 0) begin
                gen_partial(m);
                send_all();
            end
            step++;
        end

        wait_drained();
        repeat (4) @(negedge aclk);
        $display("covered %0d bytes in %0d mode settings: %0d frames committed, %0d dropped",
                 sent_bytes, mode_writes, board.commits, board.drops);
        if (board.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/sfr_pkg.sv
design/serial_frame_receiver.sv
test/serial_frame_receiver_tb.sv
